@@ rtl/cbgwm_pkg.sv @@
// Shared types, constants and helper functions of the genome window matcher.
`timescale 1ns / 1ps

package cbgwm_pkg;

  // Default sizes of the genome store and of the promoter window.
  localparam int GENOME_BITS_DEF   = 4096;
  localparam int PROMOTER_BITS_DEF = 22;

  // Fixed field widths.
  localparam int REQ_TYPE_W = 2;
  localparam int POS_W      = 12;
  localparam int GLEN_W     = 13;
  localparam int PROM_PAT_W = 22;
  localparam int SS_W       = 16;
  localparam int TERM_W     = 11;
  localparam int TMIS_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int WORD_W     = 32;
  localparam int BIT_SEL_W  = 5;
  localparam int SEG_W      = 6;

  // Reset value of the genome length register.
  localparam logic [GLEN_W-1:0] GLEN_RESET = GLEN_W'(4096);

  // Request type codes.
  localparam logic [REQ_TYPE_W-1:0] REQ_SET   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_FLIP  = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GENOME_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROMOTER_PATTERN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_MASK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_PATTERN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MASK        = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic seg_issue;
    logic rmw_write;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic                  clr_last;
    logic                  new_bad;
    logic [REQ_TYPE_W-1:0] new_type;
    logic                  seg_last;
  } dp_sts_t;

  // Population count of a 32-bit word as a five-level adder tree.
  function automatic logic [5:0] popcount32(input logic [31:0] x);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    int i;
    for (i = 0; i < 16; i++) begin
      l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    end
    for (i = 0; i < 8; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (i = 0; i < 4; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (i = 0; i < 2; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

@@ rtl/cbgwm_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration writes.
`timescale 1ns / 1ps

interface cbgwm_req_if;
  logic                             valid;
  logic                             ready;
  logic [cbgwm_pkg::REQ_TYPE_W-1:0] req_type;
  logic [cbgwm_pkg::POS_W-1:0]      position;
  logic                             bit_value;

  modport source (output valid, req_type, position, bit_value, input ready);
  modport sink   (input valid, req_type, position, bit_value, output ready);
endinterface

interface cbgwm_res_if #(
  parameter int DIST_W = $clog2(cbgwm_pkg::PROMOTER_BITS_DEF + 1)
);
  logic                         valid;
  logic                         ready;
  logic [DIST_W-1:0]            promoter_distance;
  logic [cbgwm_pkg::TMIS_W-1:0] terminator_mismatch;
  logic                         start_found;
  logic                         stop_found;
  logic                         bad_position;

  modport source (output valid, promoter_distance, terminator_mismatch, start_found,
                  stop_found, bad_position, input ready);
  modport sink   (input valid, promoter_distance, terminator_mismatch, start_found,
                  stop_found, bad_position, output ready);
endinterface

interface cbgwm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbgwm_pkg::CFG_IDX_W-1:0]  index;
  logic [cbgwm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/circular_bit_genome_window_matcher.sv @@
// Top level of the circular bit genome window matcher.
`timescale 1ns / 1ps

// The genome lives in a word memory of GENOME_BITS/32 words (128 by default) with one
// write and one registered read port. After reset the block sweeps that memory to zero,
// one word a cycle, so requests are held off until the sweep is done; configuration
// writes are taken at any time. A request at or beyond the genome length (or with an
// unused request code) goes straight to its result; a set or flip is a read and a
// write-back of one memory word; and a query gathers the window from S word pieces, one
// memory read each (S is 1 or 2 for a window that does not wrap, 3 when it wraps past
// the end, up to the window width for a genome shorter than the window). Each result
// word sits in an output register, and the next request is accepted while it waits to
// be taken.
module circular_bit_genome_window_matcher #(
  parameter int GENOME_BITS   = cbgwm_pkg::GENOME_BITS_DEF,
  parameter int PROMOTER_BITS = cbgwm_pkg::PROMOTER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cbgwm_req_if.sink   req,
  cbgwm_res_if.source res,
  cbgwm_cfg_if.sink   cfg
);

  localparam int DIST_W = $clog2(PROMOTER_BITS + 1);

  cbgwm_pkg::dp_cmd_t cmd;
  cbgwm_pkg::dp_sts_t sts;
  logic [DIST_W-1:0]  promoter_distance;

  // Configuration writes never stall.
  assign cfg.ready = 1'b1;
  assign res.promoter_distance = promoter_distance;

  cbgwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cbgwm_dp #(
    .GENOME_BITS   (GENOME_BITS),
    .PROMOTER_BITS (PROMOTER_BITS),
    .DIST_W        (DIST_W)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .req_type            (req.req_type),
    .position            (req.position),
    .bit_value           (req.bit_value),
    .cfg_we              (cfg.valid),
    .cfg_index           (cfg.index),
    .cfg_data            (cfg.data),
    .promoter_distance   (promoter_distance),
    .terminator_mismatch (res.terminator_mismatch),
    .start_found         (res.start_found),
    .stop_found          (res.stop_found),
    .bad_position        (res.bad_position)
  );

endmodule

@@ rtl/cbgwm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cbgwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cbgwm_dp.sv @@
// Datapath: configuration registers, genome store, window assembly and result logic.
`timescale 1ns / 1ps

module cbgwm_dp #(
  parameter int GENOME_BITS   = cbgwm_pkg::GENOME_BITS_DEF,
  parameter int PROMOTER_BITS = cbgwm_pkg::PROMOTER_BITS_DEF,
  parameter int DIST_W        = $clog2(PROMOTER_BITS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cbgwm_pkg::dp_cmd_t               cmd,
  output cbgwm_pkg::dp_sts_t               sts,
  input  logic [cbgwm_pkg::REQ_TYPE_W-1:0] req_type,
  input  logic [cbgwm_pkg::POS_W-1:0]      position,
  input  logic                             bit_value,
  input  logic                             cfg_we,
  input  logic [cbgwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbgwm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [DIST_W-1:0]                promoter_distance,
  output logic [cbgwm_pkg::TMIS_W-1:0]     terminator_mismatch,
  output logic                             start_found,
  output logic                             stop_found,
  output logic                             bad_position
);

  localparam int WORDS   = (GENOME_BITS + cbgwm_pkg::WORD_W - 1) / cbgwm_pkg::WORD_W;
  localparam int AW      = $clog2(WORDS);
  localparam int IDX_W   = $clog2(GENOME_BITS);
  localparam int LEN_RAW = $clog2(GENOME_BITS + 1);
  localparam int LEN_W   = (LEN_RAW > cbgwm_pkg::GLEN_W) ? LEN_RAW : cbgwm_pkg::GLEN_W;
  localparam int WIN_W   = (PROMOTER_BITS > cbgwm_pkg::SS_W) ? PROMOTER_BITS : cbgwm_pkg::SS_W;
  localparam int FILL_W  = $clog2(WIN_W + 1);

  // Configuration registers.
  logic [cbgwm_pkg::GLEN_W-1:0]     genome_length;
  logic [cbgwm_pkg::PROM_PAT_W-1:0] promoter_pattern;
  logic [cbgwm_pkg::SS_W-1:0]       start_pattern;
  logic [cbgwm_pkg::SS_W-1:0]       start_mask;
  logic [cbgwm_pkg::SS_W-1:0]       stop_pattern;
  logic [cbgwm_pkg::SS_W-1:0]       stop_mask;

  // Request and window registers.
  logic [AW-1:0]                    clr_cnt;
  logic [IDX_W-1:0]                 idx;
  logic [cbgwm_pkg::REQ_TYPE_W-1:0] req_type_r;
  logic                             bit_value_r;
  logic                             bad_r;
  logic [FILL_W-1:0]                filled;
  logic [WIN_W-1:0]                 window;
  logic                             seg_valid;
  logic [cbgwm_pkg::BIT_SEL_W-1:0]  seg_lo;
  logic [cbgwm_pkg::SEG_W-1:0]      seg_n;
  logic [FILL_W-1:0]                seg_fill;

  // Memory port signals.
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic [cbgwm_pkg::WORD_W-1:0]     mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  logic [cbgwm_pkg::WORD_W-1:0]     mem_rdata;

  // Combinational helpers.
  logic [LEN_W-1:0]                 glen_ext;
  logic [LEN_W-1:0]                 eff_len;
  logic [LEN_W-1:0]                 room_len;
  logic [LEN_W-1:0]                 idx_sum;
  logic [IDX_W-1:0]                 idx_next;
  logic [cbgwm_pkg::SEG_W-1:0]      room_word;
  logic [cbgwm_pkg::SEG_W-1:0]      room_win;
  logic [cbgwm_pkg::SEG_W-1:0]      n_min;
  logic [cbgwm_pkg::SEG_W-1:0]      seg_len;
  logic [cbgwm_pkg::WORD_W-1:0]     bit_onehot;
  logic [cbgwm_pkg::WORD_W-1:0]     piece_mask;
  logic [cbgwm_pkg::WORD_W-1:0]     piece;
  logic [cbgwm_pkg::WORD_W-1:0]     placed;
  logic [PROMOTER_BITS-1:0]         prom_diff;
  logic [3:0]                       stem_eq;
  logic [cbgwm_pkg::TMIS_W-1:0]     tmis;
  logic                             is_query;

  // Effective length: the configured length clamped to the store size.
  assign glen_ext = LEN_W'(genome_length);
  assign eff_len  = (glen_ext > LEN_W'(GENOME_BITS)) ? LEN_W'(GENOME_BITS) : glen_ext;

  // Status toward the controller.
  assign sts.clr_last = (clr_cnt == AW'(WORDS - 1));
  assign sts.new_bad  = (LEN_W'(position) >= eff_len);
  assign sts.new_type = req_type;
  assign sts.seg_last = ((FILL_W + 1)'(filled) + (FILL_W + 1)'(seg_len)) == (FILL_W + 1)'(WIN_W);

  // Next segment of the window: stop at the word end, the wrap point or a full window.
  assign room_word = cbgwm_pkg::SEG_W'(cbgwm_pkg::WORD_W) - cbgwm_pkg::SEG_W'(idx[4:0]);
  assign room_win  = cbgwm_pkg::SEG_W'(WIN_W) - cbgwm_pkg::SEG_W'(filled);
  assign room_len  = eff_len - LEN_W'(idx);
  assign n_min     = (room_word < room_win) ? room_word : room_win;
  assign seg_len   = (room_len < LEN_W'(n_min)) ? cbgwm_pkg::SEG_W'(room_len) : n_min;
  assign idx_sum   = LEN_W'(idx) + LEN_W'(seg_len);
  assign idx_next  = (idx_sum == eff_len) ? '0 : IDX_W'(idx_sum);

  // Bits read back in the cycle after a segment was issued, placed at its window offset.
  assign piece_mask = cbgwm_pkg::WORD_W'((33'd1 << seg_n) - 33'd1);
  assign piece      = (mem_rdata >> seg_lo) & piece_mask;
  assign placed     = piece << seg_fill;

  // Write data: read-modify-write for set and flip, zeros during the clear sweep.
  assign bit_onehot = cbgwm_pkg::WORD_W'(1) << idx[4:0];
  always_comb begin
    if (req_type_r == cbgwm_pkg::REQ_SET) begin
      mem_wdata = bit_value_r ? (mem_rdata | bit_onehot) : (mem_rdata & ~bit_onehot);
    end else begin
      mem_wdata = mem_rdata ^ bit_onehot;
    end
    if (cmd.clr_step) begin
      mem_wdata = '0;
    end
  end

  // Memory addressing: the clear sweep or the word that holds the current index.
  assign mem_we    = cmd.clr_step | cmd.rmw_write;
  assign mem_raddr = AW'(idx >> cbgwm_pkg::BIT_SEL_W);
  assign mem_waddr = cmd.clr_step ? clr_cnt : mem_raddr;

  cbgwm_ram #(
    .WIDTH (cbgwm_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result logic over the assembled window.
  assign prom_diff = window[PROMOTER_BITS-1:0] ^ PROMOTER_BITS'(promoter_pattern);
  assign is_query  = (req_type_r == cbgwm_pkg::REQ_QUERY) && !bad_r;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      stem_eq[k] = (window[k] == window[cbgwm_pkg::TERM_W-1-k]);
    end
    tmis = cbgwm_pkg::TMIS_W'(stem_eq[0]) + cbgwm_pkg::TMIS_W'(stem_eq[1])
         + cbgwm_pkg::TMIS_W'(stem_eq[2]) + cbgwm_pkg::TMIS_W'(stem_eq[3]);
  end

  // Control registers: clear sweep counter and segment pipeline flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      seg_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      seg_valid <= cmd.seg_issue;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      genome_length    <= cbgwm_pkg::GLEN_RESET;
      promoter_pattern <= '0;
      start_pattern    <= '0;
      start_mask       <= '0;
      stop_pattern     <= '0;
      stop_mask        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbgwm_pkg::REG_GENOME_LENGTH:    genome_length    <= cfg_data[cbgwm_pkg::GLEN_W-1:0];
        cbgwm_pkg::REG_PROMOTER_PATTERN: promoter_pattern <= cfg_data;
        cbgwm_pkg::REG_START_PATTERN:    start_pattern    <= cfg_data[cbgwm_pkg::SS_W-1:0];
        cbgwm_pkg::REG_START_MASK:       start_mask       <= cfg_data[cbgwm_pkg::SS_W-1:0];
        cbgwm_pkg::REG_STOP_PATTERN:     stop_pattern     <= cfg_data[cbgwm_pkg::SS_W-1:0];
        cbgwm_pkg::REG_STOP_MASK:        stop_mask        <= cfg_data[cbgwm_pkg::SS_W-1:0];
        default: ;
      endcase
    end
  end

  // Request, window and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      idx         <= IDX_W'(position);
      req_type_r  <= req_type;
      bit_value_r <= bit_value;
      bad_r       <= sts.new_bad;
      filled      <= '0;
      window      <= '0;
    end else begin
      if (cmd.seg_issue) begin
        idx    <= idx_next;
        filled <= filled + FILL_W'(seg_len);
      end
      if (seg_valid) begin
        window <= window | WIN_W'(placed);
      end
    end
    if (cmd.seg_issue) begin
      seg_lo   <= idx[4:0];
      seg_n    <= seg_len;
      seg_fill <= filled;
    end
    if (cmd.load_out) begin
      promoter_distance   <= is_query ? DIST_W'(cbgwm_pkg::popcount32(
                                          cbgwm_pkg::WORD_W'(prom_diff))) : '0;
      terminator_mismatch <= is_query ? tmis : '0;
      start_found         <= is_query &&
                             ((window[cbgwm_pkg::SS_W-1:0] & start_mask) == start_pattern);
      stop_found          <= is_query &&
                             ((window[cbgwm_pkg::SS_W-1:0] & stop_mask) == stop_pattern);
      bad_position        <= bad_r;
    end
  end

`ifndef NO_ASSERTIONS
  // A segment placed into the window never runs past its top bit.
  a_seg_fits: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> ((FILL_W + 1)'(seg_fill) + (FILL_W + 1)'(seg_n)) <= (FILL_W + 1)'(WIN_W))
    else $error("window segment overruns the window");

  // A segment is issued only for an index inside the genome.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.seg_issue |-> (LEN_W'(idx) < eff_len))
    else $error("segment index beyond genome length");
`endif

endmodule

@@ rtl/cbgwm_ctrl.sv @@
// Controller: sequences clearing, read-modify-write, window reads and result hand-off.
`timescale 1ns / 1ps

module cbgwm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               res_valid,
  input  logic               res_ready,
  output cbgwm_pkg::dp_cmd_t cmd,
  input  cbgwm_pkg::dp_sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_SEG   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       res_valid_next;
  logic       accept;
  logic       out_free;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !res_valid || res_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          if (sts.new_bad) begin
            state_next = S_DONE;
          end else begin
            case (sts.new_type)
              cbgwm_pkg::REQ_SET, cbgwm_pkg::REQ_FLIP: state_next = S_RD;
              cbgwm_pkg::REQ_QUERY:                    state_next = S_SEG;
              default:                                 state_next = S_DONE;
            endcase
          end
        end
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        cmd.rmw_write = 1'b1;
        state_next    = S_DONE;
      end
      S_SEG: begin
        cmd.seg_issue = 1'b1;
        if (sts.seg_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output word valid: set on load, cleared when the word is taken.
  always_comb begin
    res_valid_next = res_valid;
    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end
    if (cmd.load_out) begin
      res_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The output register is loaded only when its previous word is gone or leaving.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!res_valid || res_ready))
    else $error("result overwritten before it was taken");

  // Requests open only once the clearing sweep has reached the last word.
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_CLEAR && state == S_IDLE) |-> $past(sts.clr_last))
    else $error("clearing sweep left early");

  // A valid set or flip, once taken, passes through S_RD and writes its word back in S_WR.
  a_rmw_timing: assert property (@(posedge clk) disable iff (rst)
    (accept && !sts.new_bad &&
     (sts.new_type == cbgwm_pkg::REQ_SET || sts.new_type == cbgwm_pkg::REQ_FLIP))
    |-> ##2 cmd.rmw_write)
    else $error("read-modify-write did not write back on time");
`endif

endmodule
